@@ design/dtc_pkg.sv @@
// ----------------------------------------------------------------------------
// dtc_pkg: shared definitions for the dirty tile collector
// Field widths, configuration register indexes, divider lane slots and the
// population count used to report the number of newly marked tiles.
// ----------------------------------------------------------------------------
package dtc_pkg;

    localparam int unsigned COORD_W = 15;
    localparam int unsigned TSIZE_W = 13;
    localparam int unsigned GRID_W  = 7;
    localparam int unsigned ROW_W   = 6;
    localparam int unsigned MASK_W  = 64;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DIV_STEPS = COORD_W;
    localparam int unsigned NUM_LANES = 4;

    localparam logic [TSIZE_W-1:0] TILE_SIZE_RESET = 13'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_DOWN   = 2'd2;

    localparam logic [1:0] LANE_LEFT   = 2'd0;
    localparam logic [1:0] LANE_TOP    = 2'd1;
    localparam logic [1:0] LANE_RIGHT  = 2'd2;
    localparam logic [1:0] LANE_BOTTOM = 2'd3;

    // Count per byte, then add the eight byte counts.
    function automatic logic [CNT_W-1:0] popcount64(input logic [MASK_W-1:0] v);
        logic [3:0]       byte_cnt [8];
        logic [CNT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < 8; i++) begin
            byte_cnt[i] = '0;
            for (int j = 0; j < 8; j++) begin
                byte_cnt[i] = byte_cnt[i] + 4'(v[8*i+j]);
            end
            sum = sum + 7'(byte_cnt[i]);
        end
        return sum;
    endfunction

endpackage

@@ design/dirty_tile_collector.sv @@
// ----------------------------------------------------------------------------
// dirty_tile_collector: seen-bitmap tracker for damaged screen tiles
// Divides each damage rectangle by the tile size, clips the tile span to the
// grid and reports, one beat per spanned tile row, the tiles seen first; a clear empties the bitmap.
// ----------------------------------------------------------------------------
// Flow: a clear or empty item goes through S_EMPTY, which registers its beat;
// a rectangle goes through S_DIV, S_CLIP, then S_READ and S_MOD for each row,
// S_MOD registering each row beat; a span off the grid leaves S_CLIP for S_EMPTY.
// One item at a time: the next item is accepted only once the block is back in
// S_IDLE after the item's last beat, and a full result register that sits stalled holds it.
// Reset: config takes reset values; row valid bits clear, so the bitmap is empty.
// ----------------------------------------------------------------------------
module dirty_tile_collector #(
    parameter int unsigned MAX_TILES_X = 64,
    parameter int unsigned MAX_TILES_Y = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dtc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dtc_pkg::TSIZE_W-1:0]         i_cfg_data,
    // input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_action,
    input  logic [dtc_pkg::COORD_W-1:0]         i_rect_left,
    input  logic [dtc_pkg::COORD_W-1:0]         i_rect_top,
    input  logic [dtc_pkg::COORD_W-1:0]         i_rect_right,
    input  logic [dtc_pkg::COORD_W-1:0]         i_rect_bottom,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dtc_pkg::ROW_W-1:0]           o_tile_row,
    output logic [dtc_pkg::MASK_W-1:0]          o_new_tiles_mask,
    output logic [dtc_pkg::CNT_W-1:0]           o_new_tile_count,
    output logic                                o_last
);

    localparam int unsigned AW = (MAX_TILES_Y > 1) ? $clog2(MAX_TILES_Y) : 1;
    localparam logic [dtc_pkg::GRID_W-1:0] TX_LIM = dtc_pkg::GRID_W'(MAX_TILES_X);
    localparam logic [dtc_pkg::GRID_W-1:0] TY_LIM = dtc_pkg::GRID_W'(MAX_TILES_Y);
    localparam logic [3:0] LAST_STEP = 4'(dtc_pkg::DIV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CLIP,
        S_READ,
        S_MOD,
        S_EMPTY
    } t_state;

    t_state r_state, n_state;

    logic [dtc_pkg::TSIZE_W-1:0] r_tile_size, n_tile_size;
    logic [dtc_pkg::GRID_W-1:0]  r_tiles_across, n_tiles_across;
    logic [dtc_pkg::GRID_W-1:0]  r_tiles_down, n_tiles_down;
    logic [MAX_TILES_Y-1:0]      r_row_valid, n_row_valid;

    logic [3:0]                  r_step, n_step;
    logic [dtc_pkg::COORD_W-1:0] r_quo [dtc_pkg::NUM_LANES];
    logic [dtc_pkg::COORD_W-1:0] n_quo [dtc_pkg::NUM_LANES];
    logic [dtc_pkg::TSIZE_W-1:0] r_rem [dtc_pkg::NUM_LANES];
    logic [dtc_pkg::TSIZE_W-1:0] n_rem [dtc_pkg::NUM_LANES];

    logic [dtc_pkg::ROW_W-1:0]   r_min_tx, n_min_tx;
    logic [dtc_pkg::ROW_W-1:0]   r_max_tx, n_max_tx;
    logic [dtc_pkg::ROW_W-1:0]   r_max_ty, n_max_ty;
    logic [dtc_pkg::ROW_W-1:0]   r_ty, n_ty;

    logic                        r_out_valid, n_out_valid;
    logic [dtc_pkg::ROW_W-1:0]   r_out_row, n_out_row;
    logic [dtc_pkg::MASK_W-1:0]  r_out_mask, n_out_mask;
    logic [dtc_pkg::CNT_W-1:0]   r_out_count, n_out_count;
    logic                        r_out_last, n_out_last;

    logic [dtc_pkg::TSIZE_W-1:0] w_ts;
    logic [dtc_pkg::GRID_W-1:0]  w_tx_n, w_ty_n;
    logic [dtc_pkg::ROW_W-1:0]   w_lim_x, w_lim_y, w_clip_x, w_clip_y;
    logic                        w_in_fire, w_out_free, w_rect_empty;
    logic [AW-1:0]               w_row_addr;
    logic [MAX_TILES_X-1:0]      w_span, w_seen, w_fresh, w_rdata;
    logic                        w_ram_we, w_ram_re;
    logic [dtc_pkg::TSIZE_W:0]   w_shift [dtc_pkg::NUM_LANES];
    logic [dtc_pkg::TSIZE_W:0]   w_diff  [dtc_pkg::NUM_LANES];

    dtc_ram #(
        .WIDTH (MAX_TILES_X),
        .DEPTH (MAX_TILES_Y)
    ) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_row_addr),
        .i_wdata (w_seen | w_fresh),
        .i_re    (w_ram_re),
        .i_raddr (w_row_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_ts   = (r_tile_size == '0) ? dtc_pkg::TSIZE_W'(1) : r_tile_size;
        w_tx_n = (r_tiles_across > TX_LIM) ? TX_LIM : r_tiles_across;
        w_ty_n = (r_tiles_down > TY_LIM) ? TY_LIM : r_tiles_down;
        w_lim_x = dtc_pkg::ROW_W'(w_tx_n - 7'd1);
        w_lim_y = dtc_pkg::ROW_W'(w_ty_n - 7'd1);
        w_clip_x = (r_quo[dtc_pkg::LANE_RIGHT] > dtc_pkg::COORD_W'(w_lim_x))
                   ? w_lim_x : r_quo[dtc_pkg::LANE_RIGHT][dtc_pkg::ROW_W-1:0];
        w_clip_y = (r_quo[dtc_pkg::LANE_BOTTOM] > dtc_pkg::COORD_W'(w_lim_y))
                   ? w_lim_y : r_quo[dtc_pkg::LANE_BOTTOM][dtc_pkg::ROW_W-1:0];

        w_in_fire  = i_in_valid && (r_state == S_IDLE);
        w_out_free = !r_out_valid || !i_out_stall;
        w_rect_empty = (i_rect_left >= i_rect_right) || (i_rect_top >= i_rect_bottom)
                       || (w_tx_n == '0) || (w_ty_n == '0);

        w_row_addr = r_ty[AW-1:0];
        for (int n = 0; n < MAX_TILES_X; n++) begin
            w_span[n] = (7'(n) >= {1'b0, r_min_tx}) && (7'(n) <= {1'b0, r_max_tx});
        end
        // A row that has not been written since the last clear reads as empty.
        w_seen  = r_row_valid[w_row_addr] ? w_rdata : '0;
        w_fresh = w_span & ~w_seen;

        // One restoring step per lane: shift in the next dividend bit.
        for (int l = 0; l < dtc_pkg::NUM_LANES; l++) begin
            w_shift[l] = {r_rem[l], r_quo[l][dtc_pkg::COORD_W-1]};
            w_diff[l]  = w_shift[l] - {1'b0, w_ts};
        end
    end

    always_comb begin
        n_state        = r_state;
        n_tile_size    = r_tile_size;
        n_tiles_across = r_tiles_across;
        n_tiles_down   = r_tiles_down;
        n_row_valid    = r_row_valid;
        n_step         = r_step;
        n_quo          = r_quo;
        n_rem          = r_rem;
        n_min_tx       = r_min_tx;
        n_max_tx       = r_max_tx;
        n_max_ty       = r_max_ty;
        n_ty           = r_ty;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_row      = r_out_row;
        n_out_mask     = r_out_mask;
        n_out_count    = r_out_count;
        n_out_last     = r_out_last;
        w_ram_we       = 1'b0;
        w_ram_re       = 1'b0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                dtc_pkg::CFG_TILE_SIZE:    n_tile_size    = i_cfg_data;
                dtc_pkg::CFG_TILES_ACROSS: n_tiles_across = i_cfg_data[dtc_pkg::GRID_W-1:0];
                dtc_pkg::CFG_TILES_DOWN:   n_tiles_down   = i_cfg_data[dtc_pkg::GRID_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_action) begin
                        n_row_valid = '0;
                        n_state     = S_EMPTY;
                    end else if (w_rect_empty) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_quo[dtc_pkg::LANE_LEFT]   = i_rect_left;
                        n_quo[dtc_pkg::LANE_TOP]    = i_rect_top;
                        n_quo[dtc_pkg::LANE_RIGHT]  = i_rect_right - 15'd1;
                        n_quo[dtc_pkg::LANE_BOTTOM] = i_rect_bottom - 15'd1;
                        for (int l = 0; l < dtc_pkg::NUM_LANES; l++) begin
                            n_rem[l] = '0;
                        end
                        n_step  = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                for (int l = 0; l < dtc_pkg::NUM_LANES; l++) begin
                    if (!w_diff[l][dtc_pkg::TSIZE_W]) begin
                        n_rem[l] = w_diff[l][dtc_pkg::TSIZE_W-1:0];
                    end else begin
                        n_rem[l] = w_shift[l][dtc_pkg::TSIZE_W-1:0];
                    end
                    n_quo[l] = {r_quo[l][dtc_pkg::COORD_W-2:0], !w_diff[l][dtc_pkg::TSIZE_W]};
                end
                n_step = r_step + 4'd1;
                if (r_step == LAST_STEP) begin
                    n_state = S_CLIP;
                end
            end
            S_CLIP: begin
                if ((r_quo[dtc_pkg::LANE_LEFT] > dtc_pkg::COORD_W'(w_clip_x))
                        || (r_quo[dtc_pkg::LANE_TOP] > dtc_pkg::COORD_W'(w_clip_y))) begin
                    n_state = S_EMPTY;
                end else begin
                    n_min_tx = r_quo[dtc_pkg::LANE_LEFT][dtc_pkg::ROW_W-1:0];
                    n_max_tx = w_clip_x;
                    n_ty     = r_quo[dtc_pkg::LANE_TOP][dtc_pkg::ROW_W-1:0];
                    n_max_ty = w_clip_y;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                w_ram_re = 1'b1;
                n_state  = S_MOD;
            end
            S_MOD: begin
                // The read data register holds while the result side stalls.
                if (w_out_free) begin
                    w_ram_we                = 1'b1;
                    n_row_valid[w_row_addr] = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_row   = r_ty;
                    n_out_mask  = dtc_pkg::MASK_W'(w_fresh);
                    n_out_count = dtc_pkg::popcount64(dtc_pkg::MASK_W'(w_fresh));
                    n_out_last  = (r_ty == r_max_ty);
                    if (r_ty == r_max_ty) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ty    = r_ty + 6'd1;
                        n_state = S_READ;
                    end
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = '0;
                    n_out_mask  = '0;
                    n_out_count = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_tile_size    <= dtc_pkg::TILE_SIZE_RESET;
            r_tiles_across <= '0;
            r_tiles_down   <= '0;
            r_row_valid    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_tile_size    <= n_tile_size;
            r_tiles_across <= n_tiles_across;
            r_tiles_down   <= n_tiles_down;
            r_row_valid    <= n_row_valid;
            r_out_valid    <= n_out_valid;
        end
        r_step      <= n_step;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_min_tx    <= n_min_tx;
        r_max_tx    <= n_max_tx;
        r_max_ty    <= n_max_ty;
        r_ty        <= n_ty;
        r_out_row   <= n_out_row;
        r_out_mask  <= n_out_mask;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
    end

    assign o_cfg_ready      = 1'b1;
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_tile_row       = r_out_row;
    assign o_new_tiles_mask = r_out_mask;
    assign o_new_tile_count = r_out_count;
    assign o_last           = r_out_last;

    // Consecutive row beats of one rectangle walk the rows in order.
    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && w_out_free && r_ty != r_max_ty)
        |=> (r_state == S_READ && r_ty == $past(r_ty) + 6'd1))
        else $error("tile row did not advance by one between beats");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_new_tile_count == 7'($countones(o_new_tiles_mask))))
        else $error("new tile count disagrees with mask");

    // A clear beat empties the whole bitmap before the next item can start.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_action) |=> (r_row_valid == '0 && r_state == S_EMPTY))
        else $error("clear did not empty the seen bitmap");

endmodule

@@ design/dtc_ram.sv @@
// ----------------------------------------------------------------------------
// dtc_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module dtc_ram #(
    parameter int unsigned WIDTH  = 64,
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ tb/dirty_tile_collector_tb.sv @@
// ----------------------------------------------------------------------------
// dirty_tile_collector_tb: self-checking bench for the dirty tile collector
// Feeds damage rectangles and clear beats with random gaps on both channels,
// keeps a private seen bitmap to predict every tile row beat, and compares
// each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dirty_tile_collector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX_X      = 64;
    localparam int GRID_MAX_Y      = 64;
    localparam int RESET_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 800000;
    localparam int IDLE_PCT        = 38;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 19;
    localparam int MAX_PRINTS      = 100;
    localparam int N_DIRECTED      = 25;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;
    localparam logic [dtc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [dtc_pkg::ROW_W-1:0]  row;
        logic [dtc_pkg::MASK_W-1:0] mask;
        logic [dtc_pkg::CNT_W-1:0]  count;
        logic                       last;
    } t_row_beat;

    localparam t_row_beat EMPTY_BEAT = '{row: '0, mask: '0, count: '0, last: 1'b1};

    typedef enum logic {STEP_ITEM, STEP_CFG} t_step_kind;

    // For STEP_CFG rows a, b and c carry tile size, tiles across and tiles down.
    typedef struct packed {
        t_step_kind                  kind;
        logic                        act;
        logic [dtc_pkg::COORD_W-1:0] a;
        logic [dtc_pkg::COORD_W-1:0] b;
        logic [dtc_pkg::COORD_W-1:0] c;
        logic [dtc_pkg::COORD_W-1:0] d;
        logic                        typed;
        t_row_beat                   beat;
    } t_step;

    localparam t_step DIRECTED [N_DIRECTED] = '{
        // reset grid is empty
        '{STEP_ITEM, ACT_ADD,   15'd0,     15'd0,     15'd64,    15'd64,    1'b1, EMPTY_BEAT},
        '{STEP_ITEM, ACT_CLEAR, 15'd32767, 15'd32767, 15'd32767, 15'd32767, 1'b1, EMPTY_BEAT},
        '{STEP_CFG,  ACT_ADD,   15'd64,    15'd64,    15'd64,    15'd0,     1'b0, EMPTY_BEAT},
        // whole grid twice: all tiles fresh, then nothing new in any row
        '{STEP_ITEM, ACT_ADD,   15'd0,     15'd0,     15'd32767, 15'd32767, 1'b0, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd0,     15'd0,     15'd32767, 15'd32767, 1'b0, EMPTY_BEAT},
        '{STEP_ITEM, ACT_CLEAR, 15'd0,     15'd0,     15'd0,     15'd0,     1'b1, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd100,   15'd0,     15'd100,   15'd50,    1'b1, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd0,     15'd200,   15'd50,    15'd200,   1'b1, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd32767, 15'd0,     15'd0,     15'd32767, 1'b1, EMPTY_BEAT},
        // span starts past the last column, then past the last row
        '{STEP_ITEM, ACT_ADD,   15'd4096,  15'd0,     15'd5000,  15'd64,    1'b1, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd0,     15'd4096,  15'd64,    15'd32767, 1'b1, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd63,    15'd63,    15'd65,    15'd65,    1'b0, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd4032,  15'd4032,  15'd32767, 15'd32767, 1'b0, EMPTY_BEAT},
        // zero tile size acts as one, oversized grid saturates
        '{STEP_CFG,  ACT_ADD,   15'd0,     15'd127,   15'd100,   15'd0,     1'b0, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd5,     15'd2,     15'd9,     15'd4,     1'b0, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd0,     15'd0,     15'd1,     15'd1,     1'b0, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd60,    15'd60,    15'd32767, 15'd32767, 1'b0, EMPTY_BEAT},
        '{STEP_CFG,  ACT_ADD,   15'd4096,  15'd1,     15'd1,     15'd0,     1'b0, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd0,     15'd0,     15'd32767, 15'd32767, 1'b0, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd4095,  15'd4095,  15'd4097,  15'd4097,  1'b0, EMPTY_BEAT},
        '{STEP_ITEM, ACT_CLEAR, 15'd21845, 15'd10922, 15'd21845, 15'd10922, 1'b1, EMPTY_BEAT},
        // upper data bits on a grid register are dropped, zero rows disables
        '{STEP_CFG,  ACT_ADD,   15'd8191,  15'd8128,  15'd0,     15'd0,     1'b0, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd0,     15'd0,     15'd100,   15'd100,   1'b1, EMPTY_BEAT},
        '{STEP_CFG,  ACT_ADD,   15'd13,    15'd0,     15'd64,    15'd0,     1'b0, EMPTY_BEAT},
        '{STEP_ITEM, ACT_ADD,   15'd0,     15'd0,     15'd100,   15'd100,   1'b1, EMPTY_BEAT}
    };

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [dtc_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [dtc_pkg::TSIZE_W-1:0]       i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic                              i_action;
    logic [dtc_pkg::COORD_W-1:0]       i_rect_left;
    logic [dtc_pkg::COORD_W-1:0]       i_rect_top;
    logic [dtc_pkg::COORD_W-1:0]       i_rect_right;
    logic [dtc_pkg::COORD_W-1:0]       i_rect_bottom;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic [dtc_pkg::ROW_W-1:0]         o_tile_row;
    logic [dtc_pkg::MASK_W-1:0]        o_new_tiles_mask;
    logic [dtc_pkg::CNT_W-1:0]         o_new_tile_count;
    logic                              o_last;

    // Travels with the input beat: a hand-written expectation for that item.
    logic      note_typed;
    t_row_beat note_beat;

    logic [dtc_pkg::TSIZE_W-1:0] mdl_tile_size = dtc_pkg::TILE_SIZE_RESET;
    logic [dtc_pkg::GRID_W-1:0]  mdl_across    = '0;
    logic [dtc_pkg::GRID_W-1:0]  mdl_down      = '0;
    logic [dtc_pkg::MASK_W-1:0]  seen_map [GRID_MAX_Y] = '{default: '0};
    t_row_beat                   row_beats_due [$];

    int   mismatches   = 0;
    int   cycle_count  = 0;
    int   hold_cnt     = 0;
    bit   calm         = 1'b0;
    bit   hold_pending = 1'b0;
    bit   hold_taken   = 1'b0;

    dirty_tile_collector dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_rect_left      (i_rect_left),
        .i_rect_top       (i_rect_top),
        .i_rect_right     (i_rect_right),
        .i_rect_bottom    (i_rect_bottom),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_tile_row       (o_tile_row),
        .o_new_tiles_mask (o_new_tiles_mask),
        .o_new_tile_count (o_new_tile_count),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTS) begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
        mismatches++;
    endtask

    // Appends one expected beat at the tail of the queue.
    task automatic enqueue_beat(input t_row_beat bt);
        row_beats_due = {row_beats_due, bt};
    endtask

    function automatic logic [dtc_pkg::COORD_W-1:0] clamp_coord(input int v);
        return (v > 32767) ? 15'h7FFF : dtc_pkg::COORD_W'(v);
    endfunction

    // Works out the row beats of one item and updates the private bitmap.
    task automatic predict_tile_rows(input logic act,
                                     input logic [dtc_pkg::COORD_W-1:0] l, t, r, b,
                                     input logic keep);
        int ts, nx, ny, x0, y0, x1, y1, span;
        logic [dtc_pkg::MASK_W-1:0] span_mask, fresh;
        t_row_beat beat;
        if (act == ACT_CLEAR) begin
            foreach (seen_map[i]) seen_map[i] = '0;
            if (keep) enqueue_beat(EMPTY_BEAT);
            return;
        end
        nx = (mdl_across > GRID_MAX_X) ? GRID_MAX_X : int'(mdl_across);
        ny = (mdl_down > GRID_MAX_Y) ? GRID_MAX_Y : int'(mdl_down);
        if (l >= r || t >= b || nx == 0 || ny == 0) begin
            if (keep) enqueue_beat(EMPTY_BEAT);
            return;
        end
        ts = (mdl_tile_size == 0) ? 1 : int'(mdl_tile_size);
        x0 = int'(l) / ts;
        y0 = int'(t) / ts;
        x1 = (int'(r) - 1) / ts;
        y1 = (int'(b) - 1) / ts;
        if (x1 > nx - 1) x1 = nx - 1;
        if (y1 > ny - 1) y1 = ny - 1;
        if (x0 > x1 || y0 > y1) begin
            if (keep) enqueue_beat(EMPTY_BEAT);
            return;
        end
        span = x1 - x0 + 1;
        span_mask = (span >= 64) ? '1 : ((64'd1 << span) - 64'd1);
        span_mask = span_mask << x0;
        for (int y = y0; y <= y1; y++) begin
            fresh       = span_mask & ~seen_map[y];
            seen_map[y] = seen_map[y] | fresh;
            beat.row    = dtc_pkg::ROW_W'(y);
            beat.mask   = fresh;
            beat.count  = dtc_pkg::CNT_W'($countones(fresh));
            beat.last   = (y == y1);
            if (keep) enqueue_beat(beat);
        end
    endtask

    // All three handshakes are sampled here, before the edge's driven updates land.
    always @(posedge i_clk) begin
        t_row_beat want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    dtc_pkg::CFG_TILE_SIZE:    mdl_tile_size = i_cfg_data;
                    dtc_pkg::CFG_TILES_ACROSS: mdl_across = i_cfg_data[dtc_pkg::GRID_W-1:0];
                    dtc_pkg::CFG_TILES_DOWN:   mdl_down   = i_cfg_data[dtc_pkg::GRID_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                predict_tile_rows(i_action, i_rect_left, i_rect_top, i_rect_right,
                                  i_rect_bottom, !note_typed);
                if (note_typed) enqueue_beat(note_beat);
            end
            if (o_out_valid && !i_out_stall) begin
                if (row_beats_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat row %0d mask %h",
                                              o_tile_row, o_new_tiles_mask));
                end else begin
                    want = row_beats_due.pop_front();
                    if (o_tile_row !== want.row)
                        report_mismatch($sformatf("tile_row %0d, want %0d",
                                                  o_tile_row, want.row));
                    if (o_new_tiles_mask !== want.mask)
                        report_mismatch($sformatf("new_tiles_mask %h, want %h",
                                                  o_new_tiles_mask, want.mask));
                    if (o_new_tile_count !== want.count)
                        report_mismatch($sformatf("new_tile_count %0d, want %0d",
                                                  o_new_tile_count, want.count));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off to back the block up.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending && !hold_taken) begin
                hold_taken = 1'b1;
                i_out_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge i_clk);
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic send_item(input logic act, input logic [dtc_pkg::COORD_W-1:0] l, t, r, b,
                             input logic typed, input t_row_beat beat);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_rect_left   <= l;
        i_rect_top    <= t;
        i_rect_right  <= r;
        i_rect_bottom <= b;
        note_typed    <= typed;
        note_beat     <= beat;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic cfg_write(input logic [dtc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dtc_pkg::TSIZE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_grid(input logic [dtc_pkg::TSIZE_W-1:0] ts, across, down);
        cfg_write(dtc_pkg::CFG_TILE_SIZE, ts);
        cfg_write(dtc_pkg::CFG_TILES_ACROSS, across);
        cfg_write(dtc_pkg::CFG_TILES_DOWN, down);
        // A write past the register list must leave everything alone.
        cfg_write(CFG_UNUSED, dtc_pkg::TSIZE_W'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (row_beats_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [dtc_pkg::TSIZE_W-1:0] pick_tile_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) return dtc_pkg::TSIZE_W'($urandom_range(1, 16));
        if (roll < 80) return dtc_pkg::TSIZE_W'($urandom_range(17, 512));
        if (roll < 95) return dtc_pkg::TSIZE_W'($urandom_range(513, 4096));
        return dtc_pkg::TSIZE_W'($urandom_range(0, 8191));
    endfunction

    function automatic logic [dtc_pkg::TSIZE_W-1:0] pick_grid();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) return '0;
        if (roll < 18) return dtc_pkg::TSIZE_W'($urandom_range(65, 8191));
        return dtc_pkg::TSIZE_W'($urandom_range(1, 64));
    endfunction

    // A rectangle near the configured grid, a few tiles on a side.
    task automatic make_rect(output logic [dtc_pkg::COORD_W-1:0] l, t, r, b);
        int ts, gw, gh;
        ts = (mdl_tile_size == 0) ? 1 : int'(mdl_tile_size);
        gw = ((mdl_across > GRID_MAX_X) ? GRID_MAX_X : int'(mdl_across)) * ts;
        gh = ((mdl_down > GRID_MAX_Y) ? GRID_MAX_Y : int'(mdl_down)) * ts;
        if (gw == 0) gw = 512;
        if (gh == 0) gh = 512;
        l = clamp_coord(int'($urandom_range(0, gw + ts)));
        t = clamp_coord(int'($urandom_range(0, gh + ts)));
        r = clamp_coord(int'(l) + 1 + int'($urandom_range(0, ts * $urandom_range(1, 6))));
        b = clamp_coord(int'(t) + 1 + int'($urandom_range(0, ts * $urandom_range(1, 6))));
        if ($urandom_range(19) == 0) r = 15'h7FFF;
    endtask

    initial begin
        int roll;
        logic [dtc_pkg::COORD_W-1:0] l, t, r, b;
        t_step st;

        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= dtc_pkg::CFG_TILE_SIZE;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_ADD;
        i_rect_left   <= '0;
        i_rect_top    <= '0;
        i_rect_right  <= '0;
        i_rect_bottom <= '0;
        note_typed    <= 1'b0;
        note_beat     <= EMPTY_BEAT;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            st = DIRECTED[k];
            if (st.kind == STEP_CFG) begin
                wait_idle();
                load_grid(dtc_pkg::TSIZE_W'(st.a), dtc_pkg::TSIZE_W'(st.b),
                          dtc_pkg::TSIZE_W'(st.c));
            end else begin
                send_item(st.act, st.a, st.b, st.c, st.d, st.typed, st.beat);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0:       load_grid(13'd1, 13'd64, 13'd64);
                1:       load_grid(13'd4096, 13'd64, 13'd64);
                default: load_grid(pick_tile_size(), pick_grid(), pick_grid());
            endcase
            calm = (p == 3);
            if (p == 4) hold_pending = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (roll < 10) begin
                    send_item(ACT_CLEAR, dtc_pkg::COORD_W'($urandom),
                              dtc_pkg::COORD_W'($urandom), dtc_pkg::COORD_W'($urandom),
                              dtc_pkg::COORD_W'($urandom), 1'b0, EMPTY_BEAT);
                end else if (roll < 22) begin
                    send_item(ACT_ADD, dtc_pkg::COORD_W'($urandom),
                              dtc_pkg::COORD_W'($urandom), dtc_pkg::COORD_W'($urandom),
                              dtc_pkg::COORD_W'($urandom), 1'b0, EMPTY_BEAT);
                end else begin
                    make_rect(l, t, r, b);
                    send_item(ACT_ADD, l, t, r, b, 1'b0, EMPTY_BEAT);
                end
            end
        end
        calm = 1'b0;

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && row_beats_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
